FILE: hw/rtl/dcr_pkg.sv
// Package for the disc collision block: widths, item types, rounding and saturation helpers.
`timescale 1ns / 1ps
`default_nettype none
package dcr_pkg;

    localparam int COORD_BITS = 18;
    localparam int FRAC_BITS  = 14;
    localparam int RAD_W      = 14;
    localparam int GAP_W      = 10;
    localparam int CFG_W      = RAD_W;
    localparam int CFG_ADDR_W = 2;
    localparam int MAG_W      = RAD_W + 1;
    localparam int D2_W       = 2 * MAG_W;
    localparam int LEN_W      = MAG_W;
    localparam int NRM_W      = FRAC_BITS + 2;
    localparam int WIDE_W     = 40;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAP    = 2'd1;

    localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) <<< (COORD_BITS - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] SAT_LO = -(WIDE_W'(1) <<< (COORD_BITS - 1));

    typedef struct packed {
        logic                             hit;
        logic                             zero;
        logic [2:0]                       dneg;
        logic [2:0][MAG_W-1:0]            dmag;
        logic [D2_W-1:0]                  d2;
        logic [2:0][COORD_BITS-1:0]       base;
        logic [2:0][COORD_BITS-1:0]       vel;
        logic [2:0][COORD_BITS-1:0]       svel;
    } cls_t;

    function automatic logic signed [WIDE_W-1:0] rnd_frac(input logic signed [WIDE_W-1:0] x);
        logic [WIDE_W-1:0] mag;
        logic [WIDE_W-1:0] q;
        mag = x[WIDE_W-1] ? (~x + WIDE_W'(1)) : x;
        q = (mag + (WIDE_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return x[WIDE_W-1] ? $signed(~q + WIDE_W'(1)) : $signed(q);
    endfunction

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [WIDE_W-1:0] x);
        if (x > SAT_HI)
        begin
            return SAT_HI[COORD_BITS-1:0];
        end
        else if (x < SAT_LO)
        begin
            return SAT_LO[COORD_BITS-1:0];
        end
        else
        begin
            return x[COORD_BITS-1:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dcr_front.sv
// Front end: center difference, squared distance and hit classification.
`timescale 1ns / 1ps
`default_nettype none
module dcr_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_x,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_y,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_z,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_vx,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_vy,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_vz,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_x,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_y,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_z,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_vx,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_vy,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_vz,
    input  logic [dcr_pkg::RAD_W-1:0]          disc_radius,
    output logic                               push,
    output dcr_pkg::cls_t                      entry,
    input  logic                               full
);

    localparam int CW = dcr_pkg::COORD_BITS;
    localparam int DW = dcr_pkg::COORD_BITS + 1;
    localparam int MW = dcr_pkg::MAG_W;
    localparam int SW = dcr_pkg::D2_W + 2;

    logic                       en;
    logic [CW-1:0]              pin [3];
    logic [CW-1:0]              vin [3];
    logic [CW-1:0]              sin [3];
    logic [CW-1:0]              svin [3];
    logic signed [DW-1:0]       d [3];
    logic [DW-1:0]              mag [3];
    logic [2:0]                 near;
    logic [MW-1:0]              two_r;
    logic [SW-1:0]              sum;
    logic                       hit;

    logic                       f1_vld_reg;
    logic [MW-1:0]              f1_mag_reg [3];
    logic [2:0]                 f1_neg_reg;
    logic                       f1_near_reg;
    logic [dcr_pkg::D2_W-1:0]   f1_r2_reg;
    logic [CW-1:0]              f1_pos_reg [3];
    logic [CW-1:0]              f1_vel_reg [3];
    logic [CW-1:0]              f1_spos_reg [3];
    logic [CW-1:0]              f1_svel_reg [3];

    logic                       f2_vld_reg;
    logic [dcr_pkg::D2_W-1:0]   f2_sq_reg [3];
    logic [MW-1:0]              f2_mag_reg [3];
    logic [2:0]                 f2_neg_reg;
    logic                       f2_near_reg;
    logic [dcr_pkg::D2_W-1:0]   f2_r2_reg;
    logic [CW-1:0]              f2_pos_reg [3];
    logic [CW-1:0]              f2_vel_reg [3];
    logic [CW-1:0]              f2_spos_reg [3];
    logic [CW-1:0]              f2_svel_reg [3];

    assign en       = !(f2_vld_reg && full);
    assign in_ready = en;
    assign push     = f2_vld_reg && !full;
    assign two_r    = {disc_radius, 1'b0};

    always_comb
    begin
        pin[0]  = puck_x;     pin[1]  = puck_y;     pin[2]  = puck_z;
        vin[0]  = puck_vx;    vin[1]  = puck_vy;    vin[2]  = puck_vz;
        sin[0]  = striker_x;  sin[1]  = striker_y;  sin[2]  = striker_z;
        svin[0] = striker_vx; svin[1] = striker_vy; svin[2] = striker_vz;
        for (int i = 0; i < 3; i++)
        begin
            d[i]    = DW'($signed(pin[i])) - DW'($signed(sin[i]));
            mag[i]  = d[i][DW-1] ? DW'(-d[i]) : DW'(d[i]);
            near[i] = mag[i] <= DW'(two_r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg <= in_valid;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_near_reg <= &near;
            f1_r2_reg   <= dcr_pkg::D2_W'(two_r) * dcr_pkg::D2_W'(two_r);
            for (int i = 0; i < 3; i++)
            begin
                f1_mag_reg[i]  <= mag[i][MW-1:0];
                f1_neg_reg[i]  <= d[i][DW-1];
                f1_pos_reg[i]  <= pin[i];
                f1_vel_reg[i]  <= vin[i];
                f1_spos_reg[i] <= sin[i];
                f1_svel_reg[i] <= svin[i];
            end
            f2_near_reg <= f1_near_reg;
            f2_r2_reg   <= f1_r2_reg;
            f2_neg_reg  <= f1_neg_reg;
            for (int i = 0; i < 3; i++)
            begin
                f2_sq_reg[i]   <= dcr_pkg::D2_W'(f1_mag_reg[i]) * dcr_pkg::D2_W'(f1_mag_reg[i]);
                f2_mag_reg[i]  <= f1_mag_reg[i];
                f2_pos_reg[i]  <= f1_pos_reg[i];
                f2_vel_reg[i]  <= f1_vel_reg[i];
                f2_spos_reg[i] <= f1_spos_reg[i];
                f2_svel_reg[i] <= f1_svel_reg[i];
            end
        end
    end

    always_comb
    begin
        sum = SW'(f2_sq_reg[0]) + SW'(f2_sq_reg[1]) + SW'(f2_sq_reg[2]);
        hit = f2_near_reg && (sum <= SW'(f2_r2_reg));
        entry.hit  = hit;
        entry.zero = (sum == '0);
        entry.dneg = f2_neg_reg;
        entry.d2   = sum[dcr_pkg::D2_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            entry.dmag[i] = f2_mag_reg[i];
            entry.base[i] = hit ? f2_spos_reg[i] : f2_pos_reg[i];
            entry.vel[i]  = f2_vel_reg[i];
            entry.svel[i] = f2_svel_reg[i];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/dcr_fifo.sv
// Short item queue between the classifying front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module dcr_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dcr_pkg::cls_t   din,
    output logic            full,
    input  logic            pop,
    output dcr_pkg::cls_t   dout,
    output logic            empty
);

    localparam int DEPTH = dcr_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    dcr_pkg::cls_t      slot_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [CNTW-1:0]    count_reg;

    assign full  = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PW'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                count_reg <= CNTW'(count_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                count_reg <= CNTW'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("item pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("item popped from empty queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == CNTW'($past(count_reg) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/dcr_back.sv
// Back end: square root, normal division, reflection and repositioning pipeline.
`timescale 1ns / 1ps
`default_nettype none
module dcr_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dcr_pkg::cls_t                      head,
    input  logic                               empty,
    output logic                               pop,
    input  logic [dcr_pkg::RAD_W-1:0]          disc_radius,
    input  logic [dcr_pkg::GAP_W-1:0]          separation_gap,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_x,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_y,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_z,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_vx,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_vy,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_vz,
    output logic                               hit
);

    localparam int CW   = dcr_pkg::COORD_BITS;
    localparam int LW   = dcr_pkg::LEN_W;
    localparam int NW   = dcr_pkg::NRM_W;
    localparam int WW   = dcr_pkg::WIDE_W;
    localparam int SQ_N = dcr_pkg::LEN_W;
    localparam int DV_N = dcr_pkg::LEN_W;
    localparam int RMW  = LW + 2;
    localparam int DRW  = LW + 1;
    localparam int RCW  = LW + 1;
    localparam int PVW  = CW + NW;
    localparam int PRW  = NW + RCW + 1;
    localparam int PJW  = CW + 4;
    localparam int PSW  = CW + 2;

    logic en;

    dcr_pkg::cls_t      sq_item_reg [SQ_N];
    logic               sq_vld_reg  [SQ_N];
    logic [RMW-1:0]     sq_rem_reg  [SQ_N];
    logic [LW-1:0]      sq_root_reg [SQ_N];

    dcr_pkg::cls_t      dv_item_reg [DV_N];
    logic               dv_vld_reg  [DV_N];
    logic [LW-1:0]      dv_len_reg  [DV_N];
    logic [DRW-1:0]     dv_rem_reg  [DV_N][3];
    logic [LW-1:0]      dv_q_reg    [DV_N][3];

    logic                   m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg;
    logic                   m1_hit_reg, m2_hit_reg, m3_hit_reg;
    logic [CW-1:0]          m1_base_reg [3];
    logic [CW-1:0]          m2_base_reg [3];
    logic [CW-1:0]          m3_base_reg [3];
    logic [CW-1:0]          m1_vel_reg [3];
    logic [CW-1:0]          m2_vel_reg [3];
    logic [CW-1:0]          m3_vel_reg [3];
    logic signed [NW-1:0]   m1_n_reg [3];
    logic signed [NW-1:0]   m2_n_reg [3];
    logic signed [PVW-1:0]  m1_pv_reg [3];
    logic signed [PVW-1:0]  m1_ps_reg [3];
    logic signed [PRW-1:0]  m1_pr_reg [3];
    logic signed [PJW-1:0]  m2_proj_reg;
    logic signed [PJW-1:0]  m2_sp_reg;
    logic signed [PSW-1:0]  m2_pos_reg [3];
    logic signed [PSW-1:0]  m3_pos_reg [3];
    logic signed [WW-1:0]   m3_mn_reg [3];
    logic signed [WW-1:0]   m3_mt_reg [3];
    logic                   m3_sppos_reg;
    logic [CW-1:0]          out_pos_reg [3];
    logic [CW-1:0]          out_vel_reg [3];
    logic                   out_hit_reg;

    dcr_pkg::cls_t          last_item;
    logic signed [NW-1:0]   n [3];
    logic [RCW-1:0]         reach;
    logic signed [WW-1:0]   acc_v, acc_s, proj_w, sp_w;
    logic signed [WW-1:0]   nv [3];

    assign en        = !m4_vld_reg || out_ready;
    assign pop       = en && !empty;
    assign out_valid = m4_vld_reg;

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sq
        dcr_pkg::cls_t      item_in;
        logic               vld_in;
        logic [RMW-1:0]     rem_in;
        logic [LW-1:0]      root_in;
        logic [RMW+1:0]     part;
        logic [RMW-1:0]     trial;

        if (k == 0)
        begin : g_first
            assign item_in = head;
            assign vld_in  = !empty;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign item_in = sq_item_reg[k-1];
            assign vld_in  = sq_vld_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
        end

        assign part  = {rem_in, item_in.d2[dcr_pkg::D2_W-1-2*k -: 2]};
        assign trial = {root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_item_reg[k] <= item_in;
                if (part >= (RMW+2)'(trial))
                begin
                    sq_rem_reg[k]  <= RMW'(part - (RMW+2)'(trial));
                    sq_root_reg[k] <= {root_in[LW-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[k]  <= part[RMW-1:0];
                    sq_root_reg[k] <= {root_in[LW-2:0], 1'b0};
                end
            end
        end
    end

    for (genvar k = 0; k < DV_N; k++)
    begin : g_dv
        dcr_pkg::cls_t      item_in;
        logic               vld_in;
        logic [LW-1:0]      len_in;
        logic [DRW-1:0]     rem_in [3];
        logic [LW-1:0]      q_in [3];
        logic [DRW:0]       part [3];
        logic [DRW:0]       dvsr;
        logic [2:0]         ge;

        if (k == 0)
        begin : g_first
            assign item_in = sq_item_reg[SQ_N-1];
            assign vld_in  = sq_vld_reg[SQ_N-1];
            assign len_in  = sq_root_reg[SQ_N-1];
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = {1'b0, sq_item_reg[SQ_N-1].dmag[i]};
                    q_in[i]   = '0;
                end
            end
        end
        else
        begin : g_next
            assign item_in = dv_item_reg[k-1];
            assign vld_in  = dv_vld_reg[k-1];
            assign len_in  = dv_len_reg[k-1];
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = dv_rem_reg[k-1][i];
                    q_in[i]   = dv_q_reg[k-1][i];
                end
            end
        end

        assign dvsr = {1'b0, len_in, 1'b0};

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                part[i] = {rem_in[i], len_in[LW-1-k]};
                ge[i]   = part[i] >= dvsr;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_item_reg[k] <= item_in;
                dv_len_reg[k]  <= len_in;
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[k][i] <= ge[i] ? DRW'(part[i] - dvsr) : part[i][DRW-1:0];
                    dv_q_reg[k][i]   <= {q_in[i][LW-2:0], ge[i]};
                end
            end
        end
    end

    assign last_item = dv_item_reg[DV_N-1];
    assign reach     = {RCW'(RCW'(disc_radius) + RCW'(separation_gap))} << 1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (last_item.zero)
            begin
                n[i] = (i == 2) ? NW'(1 << dcr_pkg::FRAC_BITS) : '0;
            end
            else if (last_item.dneg[i])
            begin
                n[i] = -$signed(NW'(dv_q_reg[DV_N-1][i]));
            end
            else
            begin
                n[i] = $signed(NW'(dv_q_reg[DV_N-1][i]));
            end
        end
        acc_v  = WW'(m1_pv_reg[0]) + WW'(m1_pv_reg[1]) + WW'(m1_pv_reg[2]);
        acc_s  = WW'(m1_ps_reg[0]) + WW'(m1_ps_reg[1]) + WW'(m1_ps_reg[2]);
        proj_w = dcr_pkg::rnd_frac(acc_v);
        sp_w   = dcr_pkg::rnd_frac(acc_s);
        for (int i = 0; i < 3; i++)
        begin
            nv[i] = WW'($signed(m3_vel_reg[i])) - dcr_pkg::rnd_frac(m3_mn_reg[i])
                  + (m3_sppos_reg ? dcr_pkg::rnd_frac(m3_mt_reg[i]) : WW'(0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg <= dv_vld_reg[DV_N-1];
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_hit_reg <= last_item.hit;
            for (int i = 0; i < 3; i++)
            begin
                m1_base_reg[i] <= last_item.base[i];
                m1_vel_reg[i]  <= last_item.vel[i];
                m1_n_reg[i]    <= n[i];
                m1_pv_reg[i]   <= $signed(last_item.vel[i]) * n[i];
                m1_ps_reg[i]   <= $signed(last_item.svel[i]) * n[i];
                m1_pr_reg[i]   <= n[i] * $signed({1'b0, reach});
            end

            m2_hit_reg  <= m1_hit_reg;
            m2_proj_reg <= proj_w[PJW-1:0];
            m2_sp_reg   <= sp_w[PJW-1:0];
            for (int i = 0; i < 3; i++)
            begin
                m2_base_reg[i] <= m1_base_reg[i];
                m2_vel_reg[i]  <= m1_vel_reg[i];
                m2_n_reg[i]    <= m1_n_reg[i];
                m2_pos_reg[i]  <= PSW'(WW'($signed(m1_base_reg[i]))
                                  + dcr_pkg::rnd_frac(WW'(m1_pr_reg[i])));
            end

            m3_hit_reg   <= m2_hit_reg;
            m3_sppos_reg <= !m2_sp_reg[PJW-1] && (m2_sp_reg != '0);
            for (int i = 0; i < 3; i++)
            begin
                m3_base_reg[i] <= m2_base_reg[i];
                m3_vel_reg[i]  <= m2_vel_reg[i];
                m3_pos_reg[i]  <= m2_pos_reg[i];
                m3_mn_reg[i]   <= (WW'(m2_n_reg[i]) * WW'(m2_proj_reg)) <<< 1;
                m3_mt_reg[i]   <= WW'(m2_n_reg[i]) * WW'(m2_sp_reg);
            end

            out_hit_reg <= m3_hit_reg;
            for (int i = 0; i < 3; i++)
            begin
                out_pos_reg[i] <= m3_hit_reg ? dcr_pkg::sat_coord(WW'(m3_pos_reg[i]))
                                             : m3_base_reg[i];
                out_vel_reg[i] <= m3_hit_reg ? dcr_pkg::sat_coord(nv[i]) : m3_vel_reg[i];
            end
        end
    end

    assign new_x  = out_pos_reg[0];
    assign new_y  = out_pos_reg[1];
    assign new_z  = out_pos_reg[2];
    assign new_vx = out_vel_reg[0];
    assign new_vy = out_vel_reg[1];
    assign new_vz = out_vel_reg[2];
    assign hit    = out_hit_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/disc_collision_reflect.sv
// Top level of the disc collision block: configuration registers and the two pipeline halves.
// One disc/striker pair enters per clock and one result leaves per clock when out_ready
// is held high. From input acceptance to out_valid an item passes two front stages, the
// four-entry queue, a 15-stage square root (one root bit per stage), a 15-stage divider
// (one quotient bit per stage for all three normal components) and four stages of
// multiply, round and saturate. A stall on the output backs up through the queue; the
// input keeps being taken until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module disc_collision_reflect (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dcr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dcr_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_x,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_y,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_z,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_vx,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_vy,
    input  logic [dcr_pkg::COORD_BITS-1:0]     puck_vz,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_x,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_y,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_z,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_vx,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_vy,
    input  logic [dcr_pkg::COORD_BITS-1:0]     striker_vz,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_x,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_y,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_z,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_vx,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_vy,
    output logic [dcr_pkg::COORD_BITS-1:0]     new_vz,
    output logic                               hit
);

    logic [dcr_pkg::RAD_W-1:0]  disc_radius_reg;
    logic [dcr_pkg::GAP_W-1:0]  separation_gap_reg;
    logic                       push;
    logic                       full;
    logic                       pop;
    logic                       empty;
    dcr_pkg::cls_t              entry;
    dcr_pkg::cls_t              head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_radius_reg    <= dcr_pkg::RAD_W'(1311);
            separation_gap_reg <= dcr_pkg::GAP_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                dcr_pkg::CFG_RADIUS: disc_radius_reg    <= cfg_data[dcr_pkg::RAD_W-1:0];
                dcr_pkg::CFG_GAP:    separation_gap_reg <= cfg_data[dcr_pkg::GAP_W-1:0];
                default:             ;
            endcase
        end
    end

    dcr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .puck_x      (puck_x),
        .puck_y      (puck_y),
        .puck_z      (puck_z),
        .puck_vx     (puck_vx),
        .puck_vy     (puck_vy),
        .puck_vz     (puck_vz),
        .striker_x   (striker_x),
        .striker_y   (striker_y),
        .striker_z   (striker_z),
        .striker_vx  (striker_vx),
        .striker_vy  (striker_vy),
        .striker_vz  (striker_vz),
        .disc_radius (disc_radius_reg),
        .push        (push),
        .entry       (entry),
        .full        (full)
    );

    dcr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (entry),
        .full  (full),
        .pop   (pop),
        .dout  (head),
        .empty (empty)
    );

    dcr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .disc_radius    (disc_radius_reg),
        .separation_gap (separation_gap_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .new_x          (new_x),
        .new_y          (new_y),
        .new_z          (new_z),
        .new_vx         (new_vx),
        .new_vy         (new_vy),
        .new_vz         (new_vz),
        .hit            (hit)
    );

endmodule
`default_nettype wire
